[hdl/prqtm_pkg.sv]
// ---------------------------------------------------------------------------
// prqtm_pkg
// Shared types and constants for the pending request queue with tag match.
// ---------------------------------------------------------------------------
package prqtm_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_DEQUEUE = 2'd1,
        FUNC_REMOVE  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        func_t       func;
        logic [15:0] request_handle;
        logic [63:0] tag;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] out_handle;
        logic [63:0] out_tag;
    } rsp_t;

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [63:0]            tag;
    } entry_t;

    typedef struct packed {
        logic        capture;
        logic [63:0] cmp_tag;
        logic        by_tag;
        logic        removing;
        logic        writing;
        entry_t      wr_entry;
    } cell_ctrl_t;

endpackage

[hdl/prqtm_cell.sv]
// ---------------------------------------------------------------------------
// prqtm_cell
// One queue slot: holds an entry, compares its tag, passes the first-match
// flag on to the next younger slot and shifts down from it on removal.
// ---------------------------------------------------------------------------
module prqtm_cell (
    input  logic                   clk,
    input  prqtm_pkg::cell_ctrl_t  ctrl,
    input  logic                   live,
    input  logic                   wr_sel,
    input  logic                   head_pick,
    input  logic                   found_in,
    input  prqtm_pkg::entry_t      nbr,
    output prqtm_pkg::entry_t      entry,
    output logic                   found_out,
    output prqtm_pkg::entry_t      taken
);
    import prqtm_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   match_reg;
    logic   hit;

    assign hit       = live & (ctrl.by_tag ? match_reg : head_pick);
    assign found_out = found_in | hit;
    assign taken     = (hit & ~found_in) ? entry_reg : '0;
    assign entry     = entry_reg;

    always_comb
    begin
        if (ctrl.removing && found_out)
        begin
            entry_next = nbr;
        end
        else if (ctrl.writing && wr_sel)
        begin
            entry_next = ctrl.wr_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            match_reg <= (entry_reg.tag == ctrl.cmp_tag);
        end
        entry_reg <= entry_next;
    end

endmodule

[hdl/pending_request_queue_tag_match_unit.sv]
// ---------------------------------------------------------------------------
// pending_request_queue_tag_match_unit
// Ordered queue of pending requests with enqueue, dequeue and removal of
// the first entry whose tag matches, built as a chain of slot cells.
// ---------------------------------------------------------------------------
//  channel  | signals                  | direction | contents
//  req      | req_valid, req_stall     | in        | func, request_handle, tag
//  rsp      | rsp_valid, rsp_stall     | out       | status, out_handle, out_tag
//
//  each transaction: the accept edge latches the tag compare in every slot,
//  then the execute state resolves the first match along the chain,
//  shifts the younger slots down or writes the new entry, and registers the result
//  reset clears the fill count, the state and the result valid flag only
//  a stalled result waits in the rsp register; the next request is still
//  taken, and waits in execute until the rsp register frees
// ---------------------------------------------------------------------------
module pending_request_queue_tag_match_unit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  prqtm_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output prqtm_pkg::rsp_t  rsp
);
    import prqtm_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_t             op_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    logic             accept;
    logic             fire;
    logic             full;
    logic             found;
    cell_ctrl_t       ctrl;
    entry_t           taken_all;

    entry_t           entry  [QUEUE_DEPTH];
    entry_t           taken  [QUEUE_DEPTH];
    logic             chain  [QUEUE_DEPTH+1];

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign accept = req_valid & ~req_stall;
    assign fire   = (state_reg == S_EXEC) & (~rsp_valid_reg | ~rsp_stall);
    assign found  = chain[QUEUE_DEPTH];

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  req_stall = 1'b0;
            S_EXEC:  req_stall = 1'b1;
            default: req_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        ctrl.capture         = accept;
        ctrl.cmp_tag         = req.tag;
        ctrl.by_tag          = (op_reg.func == FUNC_REMOVE);
        ctrl.removing        = fire & ((op_reg.func == FUNC_REMOVE) ||
                                       (op_reg.func == FUNC_DEQUEUE));
        ctrl.writing         = fire & (op_reg.func == FUNC_ENQUEUE) & ~full;
        ctrl.wr_entry.handle = op_reg.request_handle[HANDLE_BITS-1:0];
        ctrl.wr_entry.tag    = op_reg.tag;
    end

    assign chain[0] = 1'b0;

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++)
        begin : g_cell
            entry_t nbr;
            logic   head_pick;
            if (k == QUEUE_DEPTH - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = entry[k+1];
            end
            if (k == 0)
            begin : g_head
                assign head_pick = (op_reg.func == FUNC_DEQUEUE);
            end
            else
            begin : g_body
                assign head_pick = 1'b0;
            end
            prqtm_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .live      (CNT_W'(k) < count_reg),
                .wr_sel    (CNT_W'(k) == count_reg),
                .head_pick (head_pick),
                .found_in  (chain[k]),
                .nbr       (nbr),
                .entry     (entry[k]),
                .found_out (chain[k+1]),
                .taken     (taken[k])
            );
        end
    endgenerate

    always_comb
    begin
        taken_all = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            taken_all = taken_all | taken[i];
        end
    end

    always_comb
    begin
        rsp_next            = '0;
        count_next          = count_reg;
        case (op_reg.func)
            FUNC_ENQUEUE:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            FUNC_DEQUEUE, FUNC_REMOVE:
            begin
                if (found)
                begin
                    count_next          = count_reg - CNT_W'(1);
                    rsp_next.out_handle = 16'(taken_all.handle);
                    rsp_next.out_tag    = taken_all.tag;
                end
                else if (op_reg.func == FUNC_DEQUEUE)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    rsp_next.status = ST_NOTFOUND;
                end
            end
            default:
            begin
                rsp_next.status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
